[design/rcfs_pkg.sv]
// Shared types and constants for the RIFF clm frame-size scanner.
// No dependencies; imported by rcfs_parser and the top level.
package rcfs_pkg;

    localparam int DEFAULT_OFFSET_BITS = 32;

    localparam logic [15:0] FALLBACK_RESET = 16'd2048;
    localparam logic [13:0] NUM_CAP        = 14'd16383;
    localparam logic [13:0] MIN_SIZE       = 14'd64;
    localparam logic [13:0] MAX_SIZE       = 14'd8192;

    // outcome codes
    localparam logic [2:0] OUT_OK       = 3'd0;
    localparam logic [2:0] OUT_NOT_RIFF = 3'd1;
    localparam logic [2:0] OUT_NO_CLM   = 3'd2;
    localparam logic [2:0] OUT_NO_MARK  = 3'd3;
    localparam logic [2:0] OUT_RANGE    = 3'd4;

    typedef struct packed {
        logic [15:0] frame_size;
        logic [2:0]  outcome;
    } result_t;

endpackage

[design/rcfs_parser.sv]
// Byte-wise RIFF chunk walker, clm marker search and decimal parse.
// Holds all per-file state; depends on rcfs_pkg.
module rcfs_parser
    import rcfs_pkg::*;
#(
    parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [15:0] fallback_size,
    output result_t     result
);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_HDR,
        PH_SKIP,
        PH_SEARCH,
        PH_LEAD,
        PH_DIG,
        PH_DONE
    } phase_t;

    localparam logic [31:0] RIFF_TAG = {8'h46, 8'h46, 8'h49, 8'h52}; // "RIFF", byte 0 low
    localparam logic [31:0] CLM_TAG  = {8'h20, 8'h6d, 8'h6c, 8'h63}; // "clm "
    localparam logic [23:0] MARK_TAG = {8'h3e, 8'h21, 8'h3c};        // "<!>"

    phase_t                 phase_reg,   phase_next;
    logic [OFFSET_BITS-1:0] offset_reg,  offset_next;
    logic [2:0]             hidx_reg,    hidx_next;
    logic                   idm_reg,     idm_next;
    logic [31:0]            clen_reg,    clen_next;
    logic [32:0]            skip_reg,    skip_next;
    logic [1:0]             mp_reg,      mp_next;
    logic [13:0]            num_reg,     num_next;
    logic                   neg_reg,     neg_next;
    logic [15:0]            held_reg,    held_next;
    logic [2:0]             outc_reg,    outc_next;

    function automatic logic is_space(logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [13:0] add_digit(logic [13:0] v, logic [7:0] b);
        logic [17:0] acc;
        acc = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {14'd0, b[3:0]};
        return (acc > {4'd0, NUM_CAP}) ? NUM_CAP : acc[13:0];
    endfunction

    function automatic logic num_ok(logic [13:0] v, logic neg);
        return !neg && v >= MIN_SIZE && v <= MAX_SIZE;
    endfunction

    logic        digit;
    logic        skip_nz;
    logic        skip_done;
    logic [32:0] skip_dec;
    logic [31:0] full_len;

    assign digit     = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    assign skip_nz   = (skip_reg != 33'd0);
    assign skip_dec  = skip_reg - {32'd0, skip_nz};
    assign skip_done = (skip_reg[32:1] == 32'd0);   // zero once decremented

    always_comb
    begin
        logic early;
        phase_next  = phase_reg;
        offset_next = offset_reg;
        hidx_next   = hidx_reg;
        idm_next    = idm_reg;
        clen_next   = clen_reg;
        skip_next   = skip_reg;
        mp_next     = mp_reg;
        num_next    = num_reg;
        neg_next    = neg_reg;
        held_next   = held_reg;
        outc_next   = outc_reg;
        early       = 1'b0;
        full_len    = clen_reg;
        full_len[8*hidx_reg[1:0] +: 8] = data_byte;

        case (phase_reg)
            PH_MAGIC:
            begin
                if (offset_reg[OFFSET_BITS-1:2] == '0
                    && data_byte != RIFF_TAG[8*offset_reg[1:0] +: 8])
                begin
                    outc_next  = OUT_NOT_RIFF;
                    phase_next = PH_DONE;
                end
                else if (offset_reg == OFFSET_BITS'(11))
                begin
                    phase_next = PH_HDR;
                    hidx_next  = 3'd0;
                    idm_next   = 1'b1;
                    clen_next  = 32'd0;
                end
            end
            PH_HDR:
            begin
                if (!hidx_reg[2])
                begin
                    if (data_byte != CLM_TAG[8*hidx_reg[1:0] +: 8])
                        idm_next = 1'b0;
                end
                else
                begin
                    clen_next = full_len;
                end
                if (hidx_reg == 3'd7)
                begin
                    if (idm_reg)
                    begin
                        skip_next = {1'b0, full_len};
                        mp_next   = 2'd0;
                        if (full_len == 32'd0)
                        begin
                            outc_next  = OUT_NO_MARK;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_SEARCH;
                        end
                    end
                    else
                    begin
                        // odd chunks carry a pad byte
                        skip_next = {1'b0, full_len} + {32'd0, full_len[0]};
                        if (full_len == 32'd0)
                        begin
                            hidx_next = 3'd0;
                            idm_next  = 1'b1;
                            clen_next = 32'd0;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
                else
                begin
                    hidx_next = hidx_reg + 3'd1;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_done)
                begin
                    phase_next = PH_HDR;
                    hidx_next  = 3'd0;
                    idm_next   = 1'b1;
                    clen_next  = 32'd0;
                end
            end
            PH_SEARCH, PH_LEAD, PH_DIG:
            begin
                skip_next = skip_dec;
                if (phase_reg == PH_SEARCH)
                begin
                    if (data_byte == 8'd0)
                    begin
                        outc_next  = OUT_NO_MARK;
                        phase_next = PH_DONE;
                        early      = 1'b1;
                    end
                    else
                    begin
                        if (mp_reg != 2'd3 && data_byte == MARK_TAG[8*mp_reg +: 8])
                            mp_next = mp_reg + 2'd1;
                        else
                            mp_next = {1'b0, data_byte == 8'h3c};
                        if (mp_next == 2'd3)
                        begin
                            phase_next = PH_LEAD;
                            num_next   = 14'd0;
                            neg_next   = 1'b0;
                        end
                    end
                end
                else if (phase_reg == PH_LEAD && is_space(data_byte))
                begin
                    // leading blanks
                end
                else if (phase_reg == PH_LEAD && data_byte == 8'h2d)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_DIG;
                end
                else if (phase_reg == PH_LEAD && data_byte == 8'h2b)
                begin
                    phase_next = PH_DIG;
                end
                else if (digit)
                begin
                    num_next   = add_digit(num_reg, data_byte);
                    phase_next = PH_DIG;
                end
                else
                begin
                    early = 1'b1;
                    if (num_ok(num_reg, neg_reg))
                    begin
                        held_next = {2'b00, num_reg};
                        outc_next = OUT_OK;
                    end
                    else
                    begin
                        outc_next = OUT_RANGE;
                    end
                    phase_next = PH_DONE;
                end
                // end of chunk data
                if (!early && skip_done)
                begin
                    if (phase_next == PH_SEARCH)
                        outc_next = OUT_NO_MARK;
                    else if (num_ok(num_next, neg_next))
                    begin
                        held_next = {2'b00, num_next};
                        outc_next = OUT_OK;
                    end
                    else
                        outc_next = OUT_RANGE;
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        if (offset_reg != '1)
            offset_next = offset_reg + OFFSET_BITS'(1);

        // end of file: settle whatever is still open
        if (last_byte && phase_next != PH_DONE)
        begin
            case (phase_next)
                PH_MAGIC:  outc_next = OUT_NOT_RIFF;
                PH_SEARCH: outc_next = OUT_NO_MARK;
                PH_LEAD, PH_DIG:
                begin
                    if (num_ok(num_next, neg_next))
                    begin
                        held_next = {2'b00, num_next};
                        outc_next = OUT_OK;
                    end
                    else
                        outc_next = OUT_RANGE;
                end
                default:   outc_next = OUT_NO_CLM;
            endcase
            phase_next = PH_DONE;
        end

        result.outcome    = outc_next;
        result.frame_size = (outc_next == OUT_OK) ? held_next : fallback_size;

        if (last_byte)
        begin
            phase_next  = PH_MAGIC;
            offset_next = '0;
            hidx_next   = 3'd0;
            idm_next    = 1'b1;
            clen_next   = 32'd0;
            skip_next   = 33'd0;
            mp_next     = 2'd0;
            num_next    = 14'd0;
            neg_next    = 1'b0;
            held_next   = 16'd0;
            outc_next   = OUT_NOT_RIFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            offset_reg <= '0;
            hidx_reg   <= 3'd0;
            idm_reg    <= 1'b1;
            clen_reg   <= 32'd0;
            skip_reg   <= 33'd0;
            mp_reg     <= 2'd0;
            num_reg    <= 14'd0;
            neg_reg    <= 1'b0;
            held_reg   <= 16'd0;
            outc_reg   <= OUT_NOT_RIFF;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            hidx_reg   <= hidx_next;
            idm_reg    <= idm_next;
            clen_reg   <= clen_next;
            skip_reg   <= skip_next;
            mp_reg     <= mp_next;
            num_reg    <= num_next;
            neg_reg    <= neg_next;
            held_reg   <= held_next;
            outc_reg   <= outc_next;
        end
    end

endmodule

[design/riff_clm_frame_size_scanner.sv]
// RIFF clm frame-size scanner: one file byte per item, one result per file.
// The last byte is registered in the input stage, and its result in the output stage that drives m_axis.
// Throughput: 1 byte per cycle; only a final byte waits, and only while the
// previous result is still held on m_axis.
// Reset (rst_n, async, active low) clears all parse state, empties both
// stages and sets the fallback size to 2048. Depends on rcfs_pkg, rcfs_parser.
module riff_clm_frame_size_scanner
    import rcfs_pkg::*;
#(
    parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // data_byte
    input  logic        s_axis_tlast,    // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // frame_size
    output logic [2:0]  m_axis_tuser,    // outcome
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data         // fallback_size
);

    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic [15:0] fallback_reg;
    logic        advance;
    result_t     result;

    // a non-final byte never needs the output slot
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.frame_size;
    assign m_axis_tuser  = out_reg.outcome;

    rcfs_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data_byte     (in_data_reg),
        .last_byte     (in_last_reg),
        .fallback_size (fallback_reg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fallback_reg  <= FALLBACK_RESET;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (cfg_valid)
                fallback_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && in_last_reg)
            out_reg <= result;
    end

`ifndef SYNTHESIS
    a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == OUT_OK) |->
        (m_axis_tdata >= 16'd64 && m_axis_tdata <= 16'd8192))
        else $error("accepted frame size outside 64..8192");

    a_fallback_used: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != OUT_OK) |-> (m_axis_tdata == fallback_reg))
        else $error("fallback size not reported on failure outcome");

    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= OUT_RANGE))
        else $error("outcome code out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && in_last_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a blocked result");
`endif

endmodule
